[rtl/smm_pkg.sv]
// ----------------------------------------------------------------------------
// smm_pkg
// Types and constants shared by the small matrix multiplier.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam logic [1:0] REQ_WRITE_A = 2'd0;
  localparam logic [1:0] REQ_WRITE_B = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  localparam logic [1:0] CFG_A_ROWS  = 2'd0;
  localparam logic [1:0] CFG_A_COLS  = 2'd1;
  localparam logic [1:0] CFG_B_ROWS  = 2'd2;
  localparam logic [1:0] CFG_B_COLS  = 2'd3;

  localparam logic [3:0] DIM_RESET   = 4'd8;

  localparam int ACC_W = 68;
  localparam int SAT_LSB = 47;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32'sd32768);
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic               last;
    logic [1:0]         status;
    logic               saturated;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last_term;
    logic       last_elem;
    logic [2:0] row;
    logic [2:0] col;
  } mac_tag_t;

endpackage

[rtl/smm_store.sv]
// ----------------------------------------------------------------------------
// smm_store
// Element stores for matrices A and B, one write port, registered reads.
// ----------------------------------------------------------------------------
module smm_store #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we_a,
  input  logic          we_b,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] a_raddr,
  input  logic [AW-1:0] b_raddr,
  output logic [31:0]   a_rdata,
  output logic [31:0]   b_rdata
);

  logic [31:0] a_mem [2**AW];
  logic [31:0] b_mem [2**AW];

  always_ff @(posedge clk) begin
    if (we_a) begin
      a_mem[waddr] <= wdata;
    end
    a_rdata <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      b_mem[waddr] <= wdata;
    end
    b_rdata <= b_mem[b_raddr];
  end

endmodule

[rtl/smm_mac.sv]
// ----------------------------------------------------------------------------
// smm_mac
// Shared multiply-accumulate unit: product, wide sum, round and saturate.
// ----------------------------------------------------------------------------
module smm_mac (
  input  logic             clk,
  input  logic             rst,
  input  smm_pkg::mac_tag_t tag,
  input  logic [31:0]      a_data,
  input  logic [31:0]      b_data,
  output logic             res_valid,
  output smm_pkg::res_t    res
);
  import smm_pkg::*;

  mac_tag_t                tag1;
  mac_tag_t                tag2;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic                    in_range;
  logic [31:0]             value_next;

  always_comb begin
    acc_next = (tag2.first ? ROUND_HALF : acc) + {{(ACC_W-64){prod[63]}}, prod};
    in_range = (&acc_next[ACC_W-1:SAT_LSB]) || !(|acc_next[ACC_W-1:SAT_LSB]);
    if (in_range) begin
      value_next = acc_next[47:16];
    end else if (acc_next[ACC_W-1]) begin
      value_next = SAT_NEG;
    end else begin
      value_next = SAT_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      tag1      <= tag;
      tag2      <= tag1;
      res_valid <= tag2.valid && tag2.last_term;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_data) * $signed(b_data);
    if (tag2.valid) begin
      acc <= acc_next;
    end
    res.value_res <= value_next;
    res.out_row   <= tag2.row;
    res.out_col   <= tag2.col;
    res.last      <= tag2.last_elem;
    res.status    <= ST_OK;
    res.saturated <= !in_range;
  end

endmodule

[rtl/small_matrix_multiply_top.sv]
// ----------------------------------------------------------------------------
// small_matrix_multiply_top
// Loads A and B element by element and emits A times B in signed Q16.16.
//
//   Channel  Signals                     Handshake
//   input    start, busy, req            beat taken when start && !busy
//   result   done, res                   one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_idx, cfg_data   write taken when cfg_we
//
// A write or rejected item gives its result the next cycle; busy stays low.
// A multiply runs one MAC per cycle on the single 32x32 multiplier:
// all a_rows*a_cols*b_cols terms issue, then the pipeline drains; busy all along.
// Reset returns the sequencer to idle and all dimension registers to 8.
// The result side cannot stall; results are never held.
// ----------------------------------------------------------------------------
module small_matrix_multiply_top #(
  parameter int MAX_DIM = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  smm_pkg::req_t req,
  output logic          done,
  output smm_pkg::res_t res,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [3:0]    cfg_data
);
  import smm_pkg::*;

  localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam logic [3:0] DIM_MAX = 4'(MAX_DIM);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [3:0]      a_rows;
  logic [3:0]      a_cols;
  logic [3:0]      b_rows;
  logic [3:0]      b_cols;
  logic [CW-1:0]   cnt_i;
  logic [CW-1:0]   cnt_j;
  logic [CW-1:0]   cnt_m;
  logic            accept;
  logic            dims_ok;
  logic            wr_ok;
  logic            go;
  logic            end_m;
  logic            end_j;
  logic            end_i;
  logic            we_a;
  logic            we_b;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   a_raddr;
  logic [AW-1:0]   b_raddr;
  logic [31:0]     a_rdata;
  logic [31:0]     b_rdata;
  mac_tag_t        tag;
  logic            mac_valid;
  res_t            mac_res;
  logic            st_valid;
  res_t            st_res;

  function automatic logic dim_ok(input logic [3:0] d);
    return (d != 4'd0) && (d <= DIM_MAX);
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (req.req_type == REQ_WRITE_B) begin
      wr_ok = dim_ok(b_rows) && dim_ok(b_cols) &&
              ({1'b0, req.row} < b_rows) && ({1'b0, req.col} < b_cols);
    end else begin
      wr_ok = dim_ok(a_rows) && dim_ok(a_cols) &&
              ({1'b0, req.row} < a_rows) && ({1'b0, req.col} < a_cols);
    end
  end

  assign dims_ok = dim_ok(a_rows) && dim_ok(a_cols) && dim_ok(b_rows) && dim_ok(b_cols);
  assign go      = accept && (req.req_type == REQ_START) && dims_ok && (a_cols == b_rows);
  assign we_a    = accept && (req.req_type == REQ_WRITE_A) && wr_ok;
  assign we_b    = accept && (req.req_type == REQ_WRITE_B) && wr_ok;
  assign waddr   = AW'(int'(req.row) * MAX_DIM + int'(req.col));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= DIM_RESET;
      a_cols <= DIM_RESET;
      b_rows <= DIM_RESET;
      b_cols <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_A_ROWS: a_rows <= cfg_data;
        CFG_A_COLS: a_cols <= cfg_data;
        CFG_B_ROWS: b_rows <= cfg_data;
        CFG_B_COLS: b_cols <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign end_m = (4'(cnt_m) == a_cols - 4'd1);
  assign end_j = (4'(cnt_j) == b_cols - 4'd1);
  assign end_i = (4'(cnt_i) == a_rows - 4'd1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (go) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (end_m && end_j && end_i) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (mac_valid && mac_res.last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cnt_i <= '0;
      cnt_j <= '0;
      cnt_m <= '0;
    end else if (state == S_ISSUE) begin
      if (!end_m) begin
        cnt_m <= cnt_m + 1'b1;
      end else begin
        cnt_m <= '0;
        if (!end_j) begin
          cnt_j <= cnt_j + 1'b1;
        end else begin
          cnt_j <= '0;
          cnt_i <= cnt_i + 1'b1;
        end
      end
    end
  end

  assign a_raddr = AW'(int'(cnt_i) * MAX_DIM + int'(cnt_m));
  assign b_raddr = AW'(int'(cnt_m) * MAX_DIM + int'(cnt_j));

  always_comb begin
    tag.valid     = (state == S_ISSUE);
    tag.first     = (cnt_m == '0);
    tag.last_term = end_m;
    tag.last_elem = end_m && end_j && end_i;
    tag.row       = 3'(cnt_i);
    tag.col       = 3'(cnt_j);
  end

  smm_store #(
    .AW(AW)
  ) u_store (
    .clk     (clk),
    .we_a    (we_a),
    .we_b    (we_b),
    .waddr   (waddr),
    .wdata   (req.value),
    .a_raddr (a_raddr),
    .b_raddr (b_raddr),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata)
  );

  smm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .tag       (tag),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .res_valid (mac_valid),
    .res       (mac_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= accept && !go;
    end
  end

  always_ff @(posedge clk) begin
    st_res.value_res <= '0;
    st_res.last      <= 1'b1;
    st_res.saturated <= 1'b0;
    case (req.req_type)
      REQ_WRITE_A, REQ_WRITE_B: begin
        st_res.out_row <= req.row;
        st_res.out_col <= req.col;
        st_res.status  <= wr_ok ? ST_OK : ST_INVALID;
      end
      REQ_START: begin
        st_res.out_row <= '0;
        st_res.out_col <= '0;
        st_res.status  <= dims_ok ? ST_MISMATCH : ST_INVALID;
      end
      default: begin
        st_res.out_row <= req.row;
        st_res.out_col <= req.col;
        st_res.status  <= ST_INVALID;
      end
    endcase
  end

  assign done = st_valid || mac_valid;
  assign res  = mac_valid ? mac_res : st_res;

endmodule

[rtl/smm_checker.sv]
// ----------------------------------------------------------------------------
// smm_checker
// Port-level checks on the small matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module smm_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input smm_pkg::req_t req,
  input logic          done,
  input smm_pkg::res_t res
);
  import smm_pkg::*;

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> busy || $past(start && !busy))
    else $error("result beat without a pending item");

  a_single_reply: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type != REQ_START) |=> (done && res.last && !busy))
    else $error("write item did not get exactly one final beat");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (done && res.status != ST_OK) |-> (res.last && res.value_res == 0 && !res.saturated))
    else $error("status beat carries data");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (done && res.saturated) |-> (res.value_res == SAT_POS || res.value_res == SAT_NEG))
    else $error("saturated beat not at a range limit");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done && res.last))
    else $error("busy dropped before the final beat");

endmodule

bind small_matrix_multiply_top smm_checker u_smm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .res   (res)
);

[verif/small_matrix_multiply_top_test.sv]
// ----------------------------------------------------------------------------
// small_matrix_multiply_top_test
// Self-checking bench for the small matrix multiplier. Loads A and B over the
// command port, starts products under many size settings, and scores every
// result strobe in order against a bit-exact Q16.16 product predictor.
// ----------------------------------------------------------------------------
module small_matrix_multiply_top_test;
  import smm_pkg::*;

  localparam int MAX_DIM = 8;
  localparam int RANDOM_ITEMS = 270;
  localparam int SHOW_LIMIT = 10;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  class matmul_predictor;
    logic [31:0] a_mem [64];
    logic [31:0] b_mem [64];
    bit          a_set [64];
    bit          b_set [64];
    logic [3:0]  dim [4];
    res_t        product_q [$];
    int          errors;

    function new();
      foreach (dim[i]) dim[i] = DIM_RESET;
      foreach (a_set[i]) begin
        a_set[i] = 1'b0;
        b_set[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function bit dim_ok(logic [3:0] d);
      return d >= 1 && d <= MAX_DIM;
    endfunction

    function void set_dim(logic [1:0] idx, logic [3:0] v);
      dim[idx] = v;
    endfunction

    function void queue_result(logic [31:0] v, logic [2:0] r, logic [2:0] c, logic lst,
                               logic [1:0] st, logic sat);
      res_t e;
      e.value_res = v;
      e.out_row   = r;
      e.out_col   = c;
      e.last      = lst;
      e.status    = st;
      e.saturated = sat;
      product_q.push_back(e);
    endfunction

    function void run_product();
      logic signed [127:0] acc;
      logic signed [63:0]  prod;
      logic [31:0]         elem;
      logic                clip;
      int                  total;
      int                  k;
      total = dim[CFG_A_ROWS] * dim[CFG_B_COLS];
      k = 0;
      for (int i = 0; i < dim[CFG_A_ROWS]; i++) begin
        for (int j = 0; j < dim[CFG_B_COLS]; j++) begin
          acc = '0;
          for (int m = 0; m < dim[CFG_A_COLS]; m++) begin
            prod = $signed(a_mem[i*MAX_DIM+m]) * $signed(b_mem[m*MAX_DIM+j]);
            acc = acc + prod;
          end
          acc = acc + 128'sd32768;
          clip = 1'b1;
          if (acc >= 128'sd140737488355328) begin
            elem = SAT_POS;
          end else if (acc < -128'sd140737488355328) begin
            elem = SAT_NEG;
          end else begin
            elem = acc[47:16];
            clip = 1'b0;
          end
          queue_result(elem, 3'(i), 3'(j), k == total - 1, ST_OK, clip);
          k++;
        end
      end
    endfunction

    function void note_request(req_t r);
      logic [3:0] nr;
      logic [3:0] nc;
      int         idx;
      idx = r.row * MAX_DIM + r.col;
      case (r.req_type)
        REQ_WRITE_A, REQ_WRITE_B: begin
          nr = (r.req_type == REQ_WRITE_B) ? dim[CFG_B_ROWS] : dim[CFG_A_ROWS];
          nc = (r.req_type == REQ_WRITE_B) ? dim[CFG_B_COLS] : dim[CFG_A_COLS];
          if (!dim_ok(nr) || !dim_ok(nc) || r.row >= nr || r.col >= nc) begin
            queue_result('0, r.row, r.col, 1'b1, ST_INVALID, 1'b0);
          end else begin
            if (r.req_type == REQ_WRITE_B) begin
              b_mem[idx] = r.value;
              b_set[idx] = 1'b1;
            end else begin
              a_mem[idx] = r.value;
              a_set[idx] = 1'b1;
            end
            queue_result('0, r.row, r.col, 1'b1, ST_OK, 1'b0);
          end
        end
        REQ_START: begin
          if (!dim_ok(dim[CFG_A_ROWS]) || !dim_ok(dim[CFG_A_COLS]) ||
              !dim_ok(dim[CFG_B_ROWS]) || !dim_ok(dim[CFG_B_COLS])) begin
            queue_result('0, '0, '0, 1'b1, ST_INVALID, 1'b0);
          end else if (dim[CFG_A_COLS] != dim[CFG_B_ROWS]) begin
            queue_result('0, '0, '0, 1'b1, ST_MISMATCH, 1'b0);
          end else begin
            run_product();
          end
        end
        default: begin
          queue_result('0, r.row, r.col, 1'b1, ST_INVALID, 1'b0);
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (product_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("unexpected beat: val=%h row=%0d col=%0d last=%0b st=%0d sat=%0b",
                   got.value_res, got.out_row, got.out_col, got.last, got.status,
                   got.saturated);
        return;
      end
      want = product_q.pop_front();
      if (got.value_res !== want.value_res || got.out_row !== want.out_row ||
          got.out_col !== want.out_col || got.last !== want.last ||
          got.status !== want.status || got.saturated !== want.saturated) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("mismatch: want val=%h row=%0d col=%0d last=%0b st=%0d sat=%0b, got val=%h row=%0d col=%0d last=%0b st=%0d sat=%0b",
                   want.value_res, want.out_row, want.out_col, want.last, want.status,
                   want.saturated, got.value_res, got.out_row, got.out_col, got.last,
                   got.status, got.saturated);
      end
    endfunction

    function void close_out();
      if (product_q.size() != 0) begin
        $display("%0d results never arrived", product_q.size());
        errors += product_q.size();
      end
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  req_t       req = '0;
  logic       done;
  res_t       res;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_A_ROWS;
  logic [3:0] cfg_data = '0;

  matmul_predictor sb = new();
  int burst_left = 0;
  int n_sent = 0;

  small_matrix_multiply_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(res);
  end

  function automatic req_t make_req(logic [1:0] kind, logic [2:0] r, logic [2:0] c,
                                    logic [31:0] v);
    req_t q;
    q.req_type = kind;
    q.row      = r;
    q.col      = c;
    q.value    = v;
    return q;
  endfunction

  function automatic logic [31:0] rand_elem();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 5))
      0:       return SAT_POS;
      1:       return SAT_NEG;
      2, 3:    return x;
      default: return {{12{x[19]}}, x[19:0]};
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 11))
      0:       return 4'd8;
      1, 2:    return 4'd1;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [3:0] bad_dim();
    if ($urandom_range(0, 3) == 0) return 4'd0;
    return 4'($urandom_range(9, 15));
  endfunction

  task automatic send_beat(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    n_sent++;
  endtask

  task automatic send_noise();
    logic [1:0] kind;
    case ($urandom_range(0, 3))
      0:       kind = REQ_UNKNOWN;
      1:       kind = REQ_WRITE_B;
      default: kind = REQ_WRITE_A;
    endcase
    send_beat(make_req(kind, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom));
  endtask

  task automatic send_start();
    send_beat(make_req(REQ_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                       $urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.product_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_dim(idx, v);
  endtask

  task automatic set_dims(logic [3:0] ar, logic [3:0] ac, logic [3:0] br, logic [3:0] bc);
    drain();
    write_reg(CFG_A_ROWS, ar);
    write_reg(CFG_A_COLS, ac);
    write_reg(CFG_B_ROWS, br);
    write_reg(CFG_B_COLS, bc);
    cfg_we <= 1'b0;
  endtask

  task automatic load_matrix(logic [1:0] kind, int nr, int nc);
    bit have;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        have = (kind == REQ_WRITE_B) ? sb.b_set[r*MAX_DIM+c] : sb.a_set[r*MAX_DIM+c];
        if (!have || $urandom_range(0, 3) != 0)
          send_beat(make_req(kind, 3'(r), 3'(c), rand_elem()));
      end
    end
  endtask

  task automatic run_phase(logic [3:0] ar, logic [3:0] ac, logic [3:0] br, logic [3:0] bc);
    set_dims(ar, ac, br, bc);
    if (sb.dim_ok(ar) && sb.dim_ok(ac)) load_matrix(REQ_WRITE_A, ar, ac);
    if (sb.dim_ok(br) && sb.dim_ok(bc)) load_matrix(REQ_WRITE_B, br, bc);
    repeat ($urandom_range(1, 2)) send_start();
    repeat ($urandom_range(0, 2)) send_noise();
  endtask

  task automatic random_phase();
    logic [3:0] ar;
    logic [3:0] ac;
    logic [3:0] br;
    logic [3:0] bc;
    int         pick;
    pick = $urandom_range(0, 19);
    ar = pick_dim();
    ac = pick_dim();
    bc = pick_dim();
    br = ac;
    if (pick < 3) begin
      while (br == ac) br = pick_dim();
    end else if (pick < 6) begin
      case ($urandom_range(0, 3))
        0:       ar = bad_dim();
        1:       ac = bad_dim();
        2:       br = bad_dim();
        default: bc = bad_dim();
      endcase
    end
    run_phase(ar, ac, br, bc);
  endtask

  task automatic directed_part();
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    send_beat(make_req(REQ_WRITE_A, 3'd0, 3'd0, SAT_NEG));
    send_beat(make_req(REQ_WRITE_B, 3'd0, 3'd0, SAT_NEG));
    send_beat(make_req(REQ_START, 3'd7, 3'd7, 32'hFFFF_FFFF));
    send_beat(make_req(REQ_WRITE_A, 3'd0, 3'd0, SAT_POS));
    send_start();
    send_beat(make_req(REQ_WRITE_B, 3'd0, 3'd0, 32'h0001_0000));
    send_start();
    send_beat(make_req(REQ_WRITE_A, 3'd0, 3'd0, SAT_NEG));
    send_start();
    send_beat(make_req(REQ_WRITE_A, 3'd0, 3'd0, 32'h0000_0001));
    send_beat(make_req(REQ_WRITE_B, 3'd0, 3'd0, 32'h0000_8000));
    send_start();
    send_beat(make_req(REQ_WRITE_A, 3'd0, 3'd0, 32'hFFFF_FFFF));
    send_start();
    send_beat(make_req(REQ_WRITE_A, 3'd1, 3'd0, 32'h1234_5678));
    send_beat(make_req(REQ_WRITE_B, 3'd7, 3'd7, 32'h8765_4321));
    send_beat(make_req(REQ_UNKNOWN, 3'd5, 3'd3, 32'hFFFF_FFFF));
    set_dims(4'd1, 4'd2, 4'd1, 4'd1);
    send_start();
    set_dims(4'd0, 4'd1, 4'd1, 4'd1);
    send_start();
    send_beat(make_req(REQ_WRITE_A, 3'd0, 3'd0, 32'h0000_0000));
    set_dims(4'd1, 4'd1, 4'd15, 4'd1);
    send_start();
    send_beat(make_req(REQ_WRITE_B, 3'd0, 3'd0, 32'h0000_0000));
  endtask

  initial begin
    int random_base;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    directed_part();
    random_base = n_sent;
    run_phase(4'd8, 4'd8, 4'd8, 4'd8);
    while (n_sent - random_base < RANDOM_ITEMS) random_phase();
    drain();
    repeat (10) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
